// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the deframer.
// Depends on a clk_i and an rst_ni visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/shcd_pkg.sv =====
// Types, codes and the CRC-32 byte update for the sync/header/CRC deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package shcd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hA5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h5A;
  localparam logic [CrcW-1:0]  CrcPoly    = 32'hEDB88320;
  localparam logic [CrcW-1:0]  CrcOnes    = 32'hFFFFFFFF;

  // Header byte positions, version first and low length byte last.
  localparam logic [2:0] HdrVersion = 3'd0;
  localparam logic [2:0] HdrType    = 3'd1;
  localparam logic [2:0] HdrSeqHi   = 3'd2;
  localparam logic [2:0] HdrSeqLo   = 3'd3;
  localparam logic [2:0] HdrLenHi   = 3'd4;
  localparam logic [2:0] HdrLenLo   = 3'd5;

  localparam logic [HalfW-1:0] CrcLastIdx = 16'd3;

  localparam logic [HalfW-1:0] MaxPayloadReset = 16'd256;
  localparam logic [ByteW-1:0] ExpVersionReset = 8'd1;

  typedef enum logic [0:0] {
    CFG_MAX_PAYLOAD = 1'b0,
    CFG_EXP_VERSION = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_GOOD     = 3'd0,
    ST_BAD_CRC  = 3'd1,
    ST_BAD_VER  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_LINE_ERR = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  // Result item; the fields below kind are packed onto tdata in this order,
  // high bits first.
  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [HalfW-1:0] frame_length;
    logic [HalfW-1:0] frame_sequence;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] frame_version;
    logic [ByteW-1:0] payload_byte;
  } result_t;

  localparam int unsigned TdataBits = $bits(result_t) - 1;
  localparam int unsigned TdataW    = ((TdataBits + 7) / 8) * 8;

  // Reflected CRC-32, one byte per call, unrolled over eight bit steps.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sync_header_crc32_deframer_top.sv =====
// Channel   | Dir | Payload                                  | Accepted when
// s_axis    | in  | tdata: rx_byte; tuser: rx_error          | tvalid & tready
// m_axis    | out | tdata: header fields, byte, status; tuser: kind | tvalid & tready
// cfg       | in  | cfg_idx_i selects, cfg_data_i value      | cfg_we_i
//
// One byte is taken every cycle while s_axis_tready is high; its result, if
// any, appears on m_axis in the next cycle from the output register. The
// CRC byte update and phase logic sit between the input and that register.
// s_axis_tready drops only while the output register holds an untaken result.
// Reset puts the block in the sync search with max_payload 256 and expected_version 1.
// Depends on shcd_pkg and shcd_core.
`default_nettype none

module sync_header_crc32_deframer_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [shcd_pkg::ByteW-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                        s_axis_tuser,  // [0] rx_error
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] payload_byte, [15:8] frame_version, [23:16] frame_type,
  // [39:24] frame_sequence, [55:40] frame_length, [58:56] status, rest zero
  output logic [shcd_pkg::TdataW-1:0]      m_axis_tdata,
  output logic                             m_axis_tuser,  // [0] out_kind
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_idx_i,
  input  wire logic [shcd_pkg::HalfW-1:0]  cfg_data_i
);
  import shcd_pkg::*;

  logic [HalfW-1:0] max_payload_q;
  logic [ByteW-1:0] exp_version_q;
  logic             in_fire;
  logic             res_valid;
  result_t          res;
  logic             out_valid_q;
  result_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
      exp_version_q <= ExpVersionReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        CFG_EXP_VERSION: exp_version_q <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  shcd_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_fire_i          (in_fire),
    .rx_byte_i          (s_axis_tdata),
    .rx_error_i         (s_axis_tuser),
    .max_payload_i      (max_payload_q),
    .expected_version_i (exp_version_q),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {{(TdataW - TdataBits){1'b0}}, out_q[TdataBits-1:0]};

endmodule

`default_nettype wire

// ===== design/shcd_core.sv =====
// Frame phase machine, header capture and running CRC of the deframer.
// Depends on shcd_pkg; consumes one accepted byte per cycle.
`default_nettype none

module shcd_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_fire_i,
  input  wire logic [shcd_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      rx_error_i,
  input  wire logic [shcd_pkg::HalfW-1:0] max_payload_i,
  input  wire logic [shcd_pkg::ByteW-1:0] expected_version_i,
  output logic                           res_valid_o,
  output shcd_pkg::result_t              res_o
);
  import shcd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [HalfW-1:0] count_q, count_d;
  logic [ByteW-1:0] hdr_version_q, hdr_version_d;
  logic [ByteW-1:0] hdr_type_q, hdr_type_d;
  logic [HalfW-1:0] hdr_seq_q, hdr_seq_d;
  logic [HalfW-1:0] hdr_len_q, hdr_len_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  // Only the first three CRC bytes are held; the fourth is the current byte.
  logic [23:0]      rx_crc_q, rx_crc_d;

  logic [CrcW-1:0]  crc_next;
  logic [HalfW-1:0] count_inc;
  logic [HalfW-1:0] len_new;
  logic             hdr_last;
  logic             too_long;
  logic             pay_done;
  logic             crc_last;

  assign crc_next  = crc_byte(crc_q, rx_byte_i);
  assign count_inc = count_q + 16'd1;
  assign len_new   = {hdr_len_q[15:8], rx_byte_i};
  assign hdr_last  = (count_q[2:0] == HdrLenLo);
  assign too_long  = (len_new > max_payload_i);
  assign pay_done  = (count_inc == hdr_len_q);
  assign crc_last  = (count_q == CrcLastIdx);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_HUNT0: begin
          if (!rx_error_i && rx_byte_i == SyncFirst) phase_d = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (rx_error_i)                    phase_d = PH_HUNT0;
          else if (rx_byte_i == SyncSecond)  phase_d = PH_HEADER;
          else if (rx_byte_i != SyncFirst)   phase_d = PH_HUNT0;
        end
        PH_HEADER: begin
          if (rx_error_i) begin
            phase_d = PH_HUNT0;
          end else if (hdr_last) begin
            if (too_long)                 phase_d = PH_HUNT0;
            else if (len_new == 16'd0)    phase_d = PH_CRC;
            else                          phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (rx_error_i)    phase_d = PH_HUNT0;
          else if (pay_done) phase_d = PH_CRC;
        end
        PH_CRC: begin
          if (rx_error_i || crc_last) phase_d = PH_HUNT0;
        end
        default: phase_d = PH_HUNT0;
      endcase
    end
  end

  // Header capture, CRC and byte count.
  always_comb begin
    count_d       = count_q;
    hdr_version_d = hdr_version_q;
    hdr_type_d    = hdr_type_q;
    hdr_seq_d     = hdr_seq_q;
    hdr_len_d     = hdr_len_q;
    crc_d         = crc_q;
    rx_crc_d      = rx_crc_q;
    if (in_fire_i) begin
      case (phase_q)
        PH_HUNT1: begin
          if (!rx_error_i && rx_byte_i == SyncSecond) begin
            count_d       = '0;
            hdr_version_d = '0;
            hdr_type_d    = '0;
            hdr_seq_d     = '0;
            hdr_len_d     = '0;
            crc_d         = CrcOnes;
            rx_crc_d      = '0;
          end
        end
        PH_HEADER: begin
          if (!rx_error_i) begin
            crc_d = crc_next;
            case (count_q[2:0])
              HdrVersion: hdr_version_d = rx_byte_i;
              HdrType:    hdr_type_d    = rx_byte_i;
              HdrSeqHi:   hdr_seq_d     = {rx_byte_i, 8'd0};
              HdrSeqLo:   hdr_seq_d     = {hdr_seq_q[15:8], rx_byte_i};
              HdrLenHi:   hdr_len_d     = {rx_byte_i, 8'd0};
              default:    hdr_len_d     = len_new;
            endcase
            count_d = hdr_last ? '0 : count_inc;
          end
        end
        PH_PAYLOAD: begin
          if (!rx_error_i) begin
            crc_d   = crc_next;
            count_d = pay_done ? '0 : count_inc;
          end
        end
        PH_CRC: begin
          if (!rx_error_i) begin
            rx_crc_d = {rx_crc_q[15:0], rx_byte_i};
            count_d  = count_inc;
          end
        end
        default: ;
      endcase
      if (phase_d == PH_HUNT0) count_d = '0;
    end
  end

  // Result item; header fields show the values after this byte.
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = KIND_VERDICT;
    res_o.status         = ST_GOOD;
    res_o.payload_byte   = '0;
    res_o.frame_version  = hdr_version_d;
    res_o.frame_type     = hdr_type_d;
    res_o.frame_sequence = hdr_seq_d;
    res_o.frame_length   = hdr_len_d;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          res_valid_o  = rx_error_i || (hdr_last && too_long);
          res_o.status = rx_error_i ? ST_LINE_ERR : ST_TOO_LONG;
        end
        PH_PAYLOAD: begin
          res_valid_o = 1'b1;
          if (rx_error_i) begin
            res_o.status = ST_LINE_ERR;
          end else begin
            res_o.kind         = KIND_PAYLOAD;
            res_o.payload_byte = rx_byte_i;
          end
        end
        PH_CRC: begin
          res_valid_o = rx_error_i || crc_last;
          if (rx_error_i)                               res_o.status = ST_LINE_ERR;
          else if (hdr_version_q != expected_version_i) res_o.status = ST_BAD_VER;
          else if ((crc_q ^ CrcOnes) != {rx_crc_q, rx_byte_i})
                                                        res_o.status = ST_BAD_CRC;
          else                                          res_o.status = ST_GOOD;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_version_q <= hdr_version_d;
    hdr_type_q    <= hdr_type_d;
    hdr_seq_q     <= hdr_seq_d;
    hdr_len_q     <= hdr_len_d;
    crc_q         <= crc_d;
    rx_crc_q      <= rx_crc_d;
  end

endmodule

`default_nettype wire

// ===== design/shcd_checker.sv =====
// Port-level checks on the deframer top level, attached by a bind below.
// Depends on shcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module shcd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [shcd_pkg::TdataW-1:0] m_axis_tdata,
  input wire logic                        m_axis_tuser
);
  import shcd_pkg::*;

  logic in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // A request that waits on the output keeps its contents.
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output request changed while stalled")

  // A new result only follows an accepted input byte.
  `ASSERT_CLK(a_no_spurious, !in_fire && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid, "result appeared without an input byte")

  // An empty output register never stalls the input.
  `ASSERT_CLK(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with no result pending")

  // Payload items carry a good status; verdicts carry a zero byte.
  `ASSERT_CLK(a_kind_fields, m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[7:0] == 8'd0) : (m_axis_tdata[58:56] == 3'd0)), "field inconsistent with item kind")

  // Nothing is offered while reset is held.
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind sync_header_crc32_deframer_top shcd_checker u_shcd_checker (.*);

`default_nettype wire
